FILE: rtl/pis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projectile intercept solver package
// Widths, constants and shared types of the intercept pipeline.
// ----------------------------------------------------------------------------
package pis_pkg;

	localparam int FRAC_BITS = 8;

	localparam int POS_W  = 24;
	localparam int VEL_W  = 21;
	localparam int SPD_W  = 21;
	localparam int D_W    = 25;
	localparam int DD_W   = 50;
	localparam int VV_W   = 42;
	localparam int DVP_W  = 46;
	localparam int DOT_W  = 47;
	localparam int SS_W   = 42;
	localparam int AA_W   = 42;
	localparam int H_W    = 96;
	localparam int ROOT_W = 48;
	localparam int N_W    = 51;
	localparam int TOL_W  = 15;
	localparam int NM_W   = N_W + TOL_W;
	localparam int NUM_W  = 50;
	localparam int DEN_W  = 48;
	localparam int HALF_W = 25;
	localparam int PP_W   = VEL_W + HALF_W;
	localparam int PROD_W = 71;
	localparam int CAP_BITS = 26;
	localparam int REM_W  = 74;
	localparam int MAG_W  = CAP_BITS + 1;
	localparam int SUM_W  = 28;

	localparam int TOL_SCALE = 10000;
	localparam int LIN_LIMIT = ((1 << (2 * FRAC_BITS)) + TOL_SCALE - 1) / TOL_SCALE;

	localparam logic signed [SUM_W-1:0] AIM_MAX = 28'sd8388607;
	localparam logic signed [SUM_W-1:0] AIM_MIN = -28'sd8388608;

	typedef logic [2:0][POS_W-1:0] pos3_t;
	typedef logic [2:0][VEL_W-1:0] vel3_t;

	typedef struct packed {
		pos3_t tgt;
		vel3_t vel;
	} side_t;

	typedef struct packed {
		side_t              side;
		logic               lin;
		logic               aneg;
		logic               disc_ok;
		logic [AA_W-1:0]    aa;
		logic [DOT_W-1:0]   dot;
		logic [DD_W-1:0]    dd;
	} sol_t;

	typedef struct packed {
		side_t              side;
		logic               ok;
		logic [NUM_W-1:0]   num;
		logic [DEN_W-1:0]   den;
	} quo_t;

endpackage

FILE: rtl/pis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intercept front end
// Offsets, squares, dot product, quadratic terms and discriminant, 7 stages.
// ----------------------------------------------------------------------------
module pis_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld,
	input  pis_pkg::pos3_t             org,
	input  pis_pkg::pos3_t             tgt,
	input  pis_pkg::vel3_t             vel,
	input  logic [pis_pkg::SPD_W-1:0]  shot,
	output logic                       vld_o,
	output logic [pis_pkg::H_W-1:0]    h,
	output pis_pkg::sol_t              sol
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [2:0][pis_pkg::D_W-1:0]    d_s1;
	pis_pkg::side_t                  side_s1, side_s2, side_s3;
	logic [pis_pkg::SPD_W-1:0]       shot_s1;

	logic [2:0][pis_pkg::DD_W-1:0]   ddp_s2;
	logic [2:0][pis_pkg::VV_W-1:0]   vvp_s2;
	logic [2:0][pis_pkg::DVP_W-1:0]  dvp_s2;
	logic [pis_pkg::SS_W-1:0]        ss_s2;

	logic [pis_pkg::DD_W-1:0]        dd_s3;
	logic [pis_pkg::VV_W-1:0]        vv_s3;
	logic [pis_pkg::DOT_W-1:0]       dot_s3;
	logic [pis_pkg::SS_W-1:0]        ss_s3;

	pis_pkg::sol_t                   sol_s4, sol_s5, sol_s6, sol_s7;
	logic [pis_pkg::DOT_W-1:0]       adot_s4;

	logic [47:0] p00_s5;
	logic [46:0] p01_s5;
	logic [45:0] p11_s5;
	logic [48:0] q00_s5, q01_s5;
	logic [42:0] q10_s5, q11_s5;

	logic [pis_pkg::H_W-1:0] dsq_s6, adp_s6, h_s7;

	logic signed [pis_pkg::DD_W-1:0]  ddp_c [3];
	logic signed [pis_pkg::VV_W-1:0]  vvp_c [3];
	logic signed [pis_pkg::DVP_W-1:0] dvp_c [3];
	logic [pis_pkg::SS_W-1:0]         ss_c;
	logic [pis_pkg::DD_W-1:0]         dd_c;
	logic [pis_pkg::VV_W-1:0]         vv_c;
	logic [pis_pkg::DOT_W-1:0]        dot_c;
	logic                             aneg_c;
	logic [pis_pkg::AA_W-1:0]         aa_c;
	logic [pis_pkg::DOT_W-1:0]        adot_c;
	logic [47:0] p00_c;
	logic [46:0] p01_c;
	logic [45:0] p11_c;
	logic [48:0] q00_c, q01_c;
	logic [42:0] q10_c, q11_c;
	logic [pis_pkg::H_W-1:0] dsq_c, adp_c, h_c;
	logic                    disc_c;
	pis_pkg::sol_t           sol7_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ddp_c[i] = $signed(d_s1[i]) * $signed(d_s1[i]);
			vvp_c[i] = $signed(side_s1.vel[i]) * $signed(side_s1.vel[i]);
			dvp_c[i] = $signed(d_s1[i]) * $signed(side_s1.vel[i]);
		end
		ss_c = shot_s1 * shot_s1;

		dd_c  = ddp_s2[0] + ddp_s2[1] + ddp_s2[2];
		vv_c  = vvp_s2[0] + vvp_s2[1] + vvp_s2[2];
		dot_c = {dvp_s2[0][pis_pkg::DVP_W-1], dvp_s2[0]}
			+ {dvp_s2[1][pis_pkg::DVP_W-1], dvp_s2[1]}
			+ {dvp_s2[2][pis_pkg::DVP_W-1], dvp_s2[2]};

		aneg_c = ss_s3 < vv_s3;
		aa_c   = aneg_c ? vv_s3 - ss_s3 : ss_s3 - vv_s3;
		adot_c = dot_s3[pis_pkg::DOT_W-1] ? -dot_s3 : dot_s3;

		p00_c = adot_s4[23:0] * adot_s4[23:0];
		p01_c = adot_s4[23:0] * adot_s4[46:24];
		p11_c = adot_s4[46:24] * adot_s4[46:24];
		q00_c = sol_s4.aa[23:0] * sol_s4.dd[24:0];
		q01_c = sol_s4.aa[23:0] * sol_s4.dd[49:25];
		q10_c = sol_s4.aa[41:24] * sol_s4.dd[24:0];
		q11_c = sol_s4.aa[41:24] * sol_s4.dd[49:25];

		dsq_c = pis_pkg::H_W'(p00_s5) + (pis_pkg::H_W'(p01_s5) << 25)
			+ (pis_pkg::H_W'(p11_s5) << 48);
		adp_c = pis_pkg::H_W'(q00_s5) + (pis_pkg::H_W'(q01_s5) << 25)
			+ (pis_pkg::H_W'(q10_s5) << 24) + (pis_pkg::H_W'(q11_s5) << 49);

		disc_c = !(sol_s6.aneg && (dsq_s6 < adp_s6));
		h_c    = sol_s6.aneg ? dsq_s6 - adp_s6 : dsq_s6 + adp_s6;

		sol7_c         = sol_s6;
		sol7_c.disc_ok = disc_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]   <= {org[i][pis_pkg::POS_W-1], org[i]}
					- {tgt[i][pis_pkg::POS_W-1], tgt[i]};
				ddp_s2[i] <= ddp_c[i];
				vvp_s2[i] <= vvp_c[i];
				dvp_s2[i] <= dvp_c[i];
			end
			side_s1.tgt <= tgt;
			side_s1.vel <= vel;
			shot_s1     <= shot;

			side_s2 <= side_s1;
			ss_s2   <= ss_c;

			side_s3 <= side_s2;
			dd_s3   <= dd_c;
			vv_s3   <= vv_c;
			dot_s3  <= dot_c;
			ss_s3   <= ss_s2;

			sol_s4.side    <= side_s3;
			sol_s4.lin     <= aa_c < pis_pkg::AA_W'(pis_pkg::LIN_LIMIT);
			sol_s4.aneg    <= aneg_c;
			sol_s4.disc_ok <= 1'b1;
			sol_s4.aa      <= aa_c;
			sol_s4.dot     <= dot_s3;
			sol_s4.dd      <= dd_s3;
			adot_s4        <= adot_c;

			sol_s5 <= sol_s4;
			p00_s5 <= p00_c;
			p01_s5 <= p01_c;
			p11_s5 <= p11_c;
			q00_s5 <= q00_c;
			q01_s5 <= q01_c;
			q10_s5 <= q10_c;
			q11_s5 <= q11_c;

			sol_s6 <= sol_s5;
			dsq_s6 <= dsq_c;
			adp_s6 <= adp_c;

			sol_s7 <= sol7_c;
			h_s7   <= h_c;
		end
	end

	assign vld_o = v_s7;
	assign h     = h_s7;
	assign sol   = sol_s7;

endmodule

FILE: rtl/pis_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intercept square root
// Floor integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module pis_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld,
	input  logic [pis_pkg::H_W-1:0]     h,
	input  pis_pkg::sol_t               sol,
	output logic                        vld_o,
	output logic [pis_pkg::ROOT_W-1:0]  root,
	output pis_pkg::sol_t               sol_o
);

	logic                        v_s    [pis_pkg::ROOT_W];
	logic [pis_pkg::H_W-1:0]     rem_s  [pis_pkg::ROOT_W];
	logic [pis_pkg::ROOT_W-1:0]  root_s [pis_pkg::ROOT_W];
	pis_pkg::sol_t               sol_s  [pis_pkg::ROOT_W];

	for (genvar k = 0; k < pis_pkg::ROOT_W; k++) begin : g_stage
		localparam int B = pis_pkg::ROOT_W - 1 - k;
		logic                        v_in;
		logic [pis_pkg::H_W-1:0]     rem_in;
		logic [pis_pkg::ROOT_W-1:0]  root_in;
		pis_pkg::sol_t               sol_in;
		logic [pis_pkg::H_W:0]       trial;

		if (k == 0) begin : g_first
			assign v_in    = vld;
			assign rem_in  = h;
			assign root_in = '0;
			assign sol_in  = sol;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign sol_in  = sol_s[k-1];
		end

		assign trial = ((pis_pkg::H_W+1)'(root_in) << (B + 1))
			+ ((pis_pkg::H_W+1)'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_in} >= trial) begin
					rem_s[k]  <= rem_in - trial[pis_pkg::H_W-1:0];
					root_s[k] <= root_in | (pis_pkg::ROOT_W'(1) << B);
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in;
				end
				sol_s[k] <= sol_in;
			end
		end
	end

	assign vld_o = v_s[pis_pkg::ROOT_W-1];
	assign root  = root_s[pis_pkg::ROOT_W-1];
	assign sol_o = sol_s[pis_pkg::ROOT_W-1];

endmodule

FILE: rtl/pis_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intercept root selection
// Candidate times, epsilon test and choice of the time fraction, 4 stages.
// ----------------------------------------------------------------------------
module pis_root (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld,
	input  logic [pis_pkg::ROOT_W-1:0]  root,
	input  pis_pkg::sol_t               sol,
	output logic                        vld_o,
	output pis_pkg::quo_t               quo
);

	logic v_s1, v_s2, v_s3, v_s4;
	pis_pkg::sol_t sol_s1, sol_s2, sol_s3;
	logic signed [pis_pkg::N_W-1:0]  n0_s1, n1_s1, lo_s2, hi_s2, lo_s3, hi_s3;
	logic signed [pis_pkg::NM_W-1:0] lom_s3, him_s3;
	pis_pkg::quo_t quo_s4;

	logic signed [pis_pkg::N_W-1:0]  dotx, rx, n0_c, n1_c;
	logic signed [pis_pkg::NM_W-1:0] lom_c, him_c, aax;
	logic lo_ok, hi_ok, lin_ok;

	always_comb begin
		dotx = {{(pis_pkg::N_W - pis_pkg::DOT_W){sol.dot[pis_pkg::DOT_W-1]}}, sol.dot};
		rx   = {{(pis_pkg::N_W - pis_pkg::ROOT_W){1'b0}}, root};
		n0_c = sol.aneg ? dotx - rx : rx - dotx;
		n1_c = sol.aneg ? dotx + rx : -dotx - rx;

		lom_c = lo_s2 * $signed(pis_pkg::TOL_W'(pis_pkg::TOL_SCALE));
		him_c = hi_s2 * $signed(pis_pkg::TOL_W'(pis_pkg::TOL_SCALE));

		aax    = {{(pis_pkg::NM_W - pis_pkg::AA_W){1'b0}}, sol_s3.aa};
		lo_ok  = lom_s3 >= aax;
		hi_ok  = him_s3 >= aax;
		lin_ok = !sol_s3.dot[pis_pkg::DOT_W-1] && (sol_s3.dot != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4} <= '0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sol_s1 <= sol;
			n0_s1  <= n0_c;
			n1_s1  <= n1_c;

			sol_s2 <= sol_s1;
			lo_s2  <= (n0_s1 < n1_s1) ? n0_s1 : n1_s1;
			hi_s2  <= (n0_s1 < n1_s1) ? n1_s1 : n0_s1;

			sol_s3 <= sol_s2;
			lo_s3  <= lo_s2;
			hi_s3  <= hi_s2;
			lom_s3 <= lom_c;
			him_s3 <= him_c;

			quo_s4.side <= sol_s3.side;
			if (sol_s3.lin) begin
				quo_s4.ok  <= lin_ok;
				quo_s4.num <= sol_s3.dd;
				quo_s4.den <= {sol_s3.dot[pis_pkg::DEN_W-2:0], 1'b0};
			end else begin
				quo_s4.ok  <= sol_s3.disc_ok && (lo_ok || hi_ok);
				quo_s4.num <= lo_ok ? lo_s3[pis_pkg::NUM_W-1:0] : hi_s3[pis_pkg::NUM_W-1:0];
				quo_s4.den <= {{(pis_pkg::DEN_W - pis_pkg::AA_W){1'b0}}, sol_s3.aa};
			end
		end
	end

	assign vld_o = v_s4;
	assign quo   = quo_s4;

endmodule

FILE: rtl/pis_move.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intercept displacement
// Velocity times time per axis, restoring quotient, add and saturate; a miss passes the target through.
// ----------------------------------------------------------------------------
module pis_move (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld,
	input  pis_pkg::quo_t   quo,
	output logic            vld_o,
	output logic            hit,
	output pis_pkg::pos3_t  aim
);

	localparam int NS = pis_pkg::CAP_BITS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	pis_pkg::quo_t quo_s1, quo_s2, quo_s3, quo_s4;
	logic [2:0][pis_pkg::VEL_W-1:0]  av_s1;
	logic [2:0]                      neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2:0][pis_pkg::PP_W-1:0]   pl_s2, ph_s2;
	logic [2:0][pis_pkg::PROD_W-1:0] prod_s3;
	logic [2:0][pis_pkg::REM_W-1:0]  rem_s4;
	logic [2:0]                      cap_s4;

	logic                              v_d   [NS];
	pis_pkg::quo_t                     quo_d [NS];
	logic [2:0]                        neg_d [NS];
	logic [2:0]                        cap_d [NS];
	logic [2:0][pis_pkg::REM_W-1:0]    rem_d [NS];
	logic [2:0][NS-1:0]                q_d   [NS];

	logic                    hit_s5;
	pis_pkg::pos3_t          aim_s5;

	logic [2:0][pis_pkg::VEL_W-1:0]  av_c;
	logic [2:0][pis_pkg::PP_W-1:0]   pl_c, ph_c;
	logic [2:0][pis_pkg::PROD_W-1:0] prod_c;
	logic [2:0]                      cap_c;
	pis_pkg::pos3_t                  aim_c;
	logic [pis_pkg::MAG_W-1:0]       mag;
	logic signed [pis_pkg::SUM_W-1:0] tx, mv, sum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			av_c[i] = quo.side.vel[i][pis_pkg::VEL_W-1] ? -quo.side.vel[i] : quo.side.vel[i];
			pl_c[i] = av_s1[i] * quo_s1.num[pis_pkg::HALF_W-1:0];
			ph_c[i] = av_s1[i] * quo_s1.num[pis_pkg::NUM_W-1:pis_pkg::HALF_W];
			prod_c[i] = pis_pkg::PROD_W'(pl_s2[i])
				+ (pis_pkg::PROD_W'(ph_s2[i]) << pis_pkg::HALF_W);
			cap_c[i] = pis_pkg::REM_W'(prod_s3[i])
				>= (pis_pkg::REM_W'(quo_s3.den) << pis_pkg::CAP_BITS);
		end
		mag = '0;
		tx  = '0;
		mv  = '0;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			mag = cap_d[NS-1][i] ? (pis_pkg::MAG_W'(1) << pis_pkg::CAP_BITS)
				: {1'b0, q_d[NS-1][i]};
			tx  = {{(pis_pkg::SUM_W - pis_pkg::POS_W){quo_d[NS-1].side.tgt[i][pis_pkg::POS_W-1]}},
				quo_d[NS-1].side.tgt[i]};
			mv  = neg_d[NS-1][i] ? -pis_pkg::SUM_W'(mag) : pis_pkg::SUM_W'(mag);
			sum = tx + mv;
			if (!quo_d[NS-1].ok) begin
				aim_c[i] = quo_d[NS-1].side.tgt[i];
			end else if (sum > pis_pkg::AIM_MAX) begin
				aim_c[i] = pis_pkg::POS_W'(pis_pkg::AIM_MAX);
			end else if (sum < pis_pkg::AIM_MIN) begin
				aim_c[i] = pis_pkg::POS_W'(pis_pkg::AIM_MIN);
			end else begin
				aim_c[i] = sum[pis_pkg::POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_d[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s1 <= quo;
			av_s1  <= av_c;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= quo.side.vel[i][pis_pkg::VEL_W-1];
			end

			quo_s2 <= quo_s1;
			neg_s2 <= neg_s1;
			pl_s2  <= pl_c;
			ph_s2  <= ph_c;

			quo_s3  <= quo_s2;
			neg_s3  <= neg_s2;
			prod_s3 <= prod_c;

			quo_s4 <= quo_s3;
			neg_s4 <= neg_s3;
			cap_s4 <= cap_c;
			for (int i = 0; i < 3; i++) begin
				rem_s4[i] <= pis_pkg::REM_W'(prod_s3[i]);
			end

			hit_s5 <= quo_d[NS-1].ok;
			aim_s5 <= aim_c;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_div
		localparam int B = NS - 1 - k;
		logic                            v_in;
		pis_pkg::quo_t                   quo_in;
		logic [2:0]                      neg_in, cap_in;
		logic [2:0][pis_pkg::REM_W-1:0]  rem_in;
		logic [2:0][NS-1:0]              q_in;
		logic [pis_pkg::REM_W-1:0]       trial;

		if (k == 0) begin : g_first
			assign v_in   = v_s4;
			assign quo_in = quo_s4;
			assign neg_in = neg_s4;
			assign cap_in = cap_s4;
			assign rem_in = rem_s4;
			assign q_in   = '0;
		end else begin : g_next
			assign v_in   = v_d[k-1];
			assign quo_in = quo_d[k-1];
			assign neg_in = neg_d[k-1];
			assign cap_in = cap_d[k-1];
			assign rem_in = rem_d[k-1];
			assign q_in   = q_d[k-1];
		end

		assign trial = pis_pkg::REM_W'(quo_in.den) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k] <= 1'b0;
			end else if (en) begin
				v_d[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_d[k] <= quo_in;
				neg_d[k] <= neg_in;
				cap_d[k] <= cap_in;
				for (int i = 0; i < 3; i++) begin
					if (rem_in[i] >= trial) begin
						rem_d[k][i] <= rem_in[i] - trial;
						q_d[k][i]   <= q_in[i] | (NS'(1) << B);
					end else begin
						rem_d[k][i] <= rem_in[i];
						q_d[k][i]   <= q_in[i];
					end
				end
			end
		end
	end

	assign vld_o = v_s5;
	assign hit   = hit_s5;
	assign aim   = aim_s5;

endmodule

FILE: rtl/projectile_intercept_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projectile intercept solver
// Earliest intercept of a constant-velocity target, fixed point, pipelined.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// solve     solve_valid / solve_ready    origin, target, velocity, shot_speed
// result    result_valid / result_ready  hit_valid, aim_x, aim_y, aim_z
//
// One transaction per cycle while the result channel is not stalled.
// The longest sections are the 48-stage square root and the 26-stage quotient per axis.
// A stalled result freezes every stage at once; solve_ready drops with it.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module projectile_intercept_solver (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             solve_valid,
	output logic                             solve_ready,
	input  logic signed [pis_pkg::POS_W-1:0] origin_x,
	input  logic signed [pis_pkg::POS_W-1:0] origin_y,
	input  logic signed [pis_pkg::POS_W-1:0] origin_z,
	input  logic signed [pis_pkg::POS_W-1:0] target_x,
	input  logic signed [pis_pkg::POS_W-1:0] target_y,
	input  logic signed [pis_pkg::POS_W-1:0] target_z,
	input  logic signed [pis_pkg::VEL_W-1:0] velocity_x,
	input  logic signed [pis_pkg::VEL_W-1:0] velocity_y,
	input  logic signed [pis_pkg::VEL_W-1:0] velocity_z,
	input  logic        [pis_pkg::SPD_W-1:0] shot_speed,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic                             hit_valid,
	output logic signed [pis_pkg::POS_W-1:0] aim_x,
	output logic signed [pis_pkg::POS_W-1:0] aim_y,
	output logic signed [pis_pkg::POS_W-1:0] aim_z
);

	logic en;
	pis_pkg::pos3_t org, tgt, aim;
	pis_pkg::vel3_t vel;

	logic                        fr_vld, sq_vld, rt_vld;
	logic [pis_pkg::H_W-1:0]     fr_h;
	pis_pkg::sol_t               fr_sol, sq_sol;
	logic [pis_pkg::ROOT_W-1:0]  sq_root;
	pis_pkg::quo_t               rt_quo;

	assign en          = !result_valid || result_ready;
	assign solve_ready = en;

	assign org = {origin_z, origin_y, origin_x};
	assign tgt = {target_z, target_y, target_x};
	assign vel = {velocity_z, velocity_y, velocity_x};

	pis_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (solve_valid),
		.org    (org),
		.tgt    (tgt),
		.vel    (vel),
		.shot   (shot_speed),
		.vld_o  (fr_vld),
		.h      (fr_h),
		.sol    (fr_sol)
	);

	pis_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (fr_vld),
		.h      (fr_h),
		.sol    (fr_sol),
		.vld_o  (sq_vld),
		.root   (sq_root),
		.sol_o  (sq_sol)
	);

	pis_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (sq_vld),
		.root   (sq_root),
		.sol    (sq_sol),
		.vld_o  (rt_vld),
		.quo    (rt_quo)
	);

	pis_move u_move (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (rt_vld),
		.quo    (rt_quo),
		.vld_o  (result_valid),
		.hit    (hit_valid),
		.aim    (aim)
	);

	assign aim_x = aim[0];
	assign aim_y = aim[1];
	assign aim_z = aim[2];

endmodule

FILE: rtl/pis_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intercept solver port checker
// Flow control and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module pis_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             solve_valid,
	input logic                             solve_ready,
	input logic                             result_valid,
	input logic                             result_ready,
	input logic                             hit_valid,
	input logic signed [pis_pkg::POS_W-1:0] aim_x,
	input logic signed [pis_pkg::POS_W-1:0] aim_y,
	input logic signed [pis_pkg::POS_W-1:0] aim_z
);

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		solve_ready == (!result_valid || result_ready))
		else $error("solve_ready does not track result stall");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable({hit_valid, aim_x, aim_y, aim_z}))
		else $error("stalled result transaction changed");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid right after reset");

	a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !(solve_valid && solve_ready))
		else $error("transaction accepted while output stalled");

endmodule

bind projectile_intercept_solver pis_check u_pis_check (.*);
